/* rtl/lruc_pkg.sv */
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared sizes, codes and types of the lru key/value cache.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;
    localparam int ITEM_BITS   = 32;
    localparam int CAP_W       = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int STATUS_W    = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_FIND   = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FOUND     = 2'd2,
        ST_MISS      = 2'd3
    } status_t;

    typedef enum logic
    {
        S_IDLE   = 1'b0,
        S_UPDATE = 1'b1
    } fsm_t;

    // per cell control broadcast from the sequencer
    typedef struct packed
    {
        logic cmp;
        logic upd;
        logic shift;
        logic load;
        logic valid_nxt;
    } cell_ctl_t;

endpackage

/* rtl/lruc_ifs.sv */
// ----------------------------------------------------------------------------
// lruc channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lruc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [lruc_pkg::KEY_BITS-1:0]  key;
    logic [lruc_pkg::ITEM_BITS-1:0] item;

    modport source (output valid, output opcode, output key, output item, input ready);
    modport sink   (input valid, input opcode, input key, input item, output ready);
endinterface

interface lruc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lruc_pkg::STATUS_W-1:0]  status;
    logic [lruc_pkg::ITEM_BITS-1:0] found_item;

    modport source (output valid, output status, output found_item, input ready);
    modport sink   (input valid, input status, input found_item, output ready);
endinterface

/* rtl/lruc_cell.sv */
// ----------------------------------------------------------------------------
// lruc_cell
// One recency slot: holds key, item and valid, compares against the probe
// key and takes its lower neighbor's entry when the order shifts.
// ----------------------------------------------------------------------------
module lruc_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lruc_pkg::cell_ctl_t           ctl,
    input  logic [lruc_pkg::KEY_BITS-1:0]  probe_key,
    input  logic [lruc_pkg::KEY_BITS-1:0]  prev_key,
    input  logic [lruc_pkg::ITEM_BITS-1:0] prev_item,
    input  logic [lruc_pkg::KEY_BITS-1:0]  head_key,
    input  logic [lruc_pkg::ITEM_BITS-1:0] head_item,
    output logic [lruc_pkg::KEY_BITS-1:0]  key,
    output logic [lruc_pkg::ITEM_BITS-1:0] item,
    output logic                          valid,
    output logic                          hit
);

    logic [lruc_pkg::KEY_BITS-1:0]  key_reg;
    logic [lruc_pkg::ITEM_BITS-1:0] item_reg;
    logic                          valid_reg;
    logic                          hit_reg;

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.upd && ctl.load)
        begin
            key_reg  <= head_key;
            item_reg <= head_item;
        end
        else if (ctl.upd && ctl.shift)
        begin
            key_reg  <= prev_key;
            item_reg <= prev_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.upd)
            begin
                valid_reg <= ctl.valid_nxt;
            end
            if (ctl.cmp)
            begin
                hit_reg <= valid_reg && (key_reg == probe_key);
            end
        end
    end

    assign key   = key_reg;
    assign item  = item_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

/* rtl/lru_key_value_cache_unit.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache kept in recency order by a chain of
// slot cells, slot 0 most recent, with least recently used eviction.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  req       in   valid/ready      opcode, key, item
//  rsp       out  valid/ready      status, found_item
//  cfg       in   cfg_we           cfg_wdata (capacity)
//
//  each transaction: all cells compare at the accept edge, the
//  next cycle shifts the recency chain and loads the response register
//  a new request is taken only in idle and once the response register is free or drains
//  reset empties the cache and sets capacity to 16; no clearing pass needed
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lruc_pkg::CAP_W-1:0]      cfg_wdata,
    lruc_req_if.sink                        req,
    lruc_rsp_if.source                      rsp
);

    localparam int N = lruc_pkg::MAX_ENTRIES;

    lruc_pkg::fsm_t                   state_reg;
    lruc_pkg::fsm_t                   state_next;
    logic [lruc_pkg::CAP_W-1:0]       capacity_reg;
    logic [lruc_pkg::CNT_W-1:0]       count_reg;
    logic                             op_reg;
    logic [lruc_pkg::KEY_BITS-1:0]    key_reg;
    logic [lruc_pkg::ITEM_BITS-1:0]   item_reg;
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;
    logic [lruc_pkg::STATUS_W-1:0]    status_reg;
    logic [lruc_pkg::ITEM_BITS-1:0]   found_reg;

    logic                             accept;
    logic                             upd;
    logic [lruc_pkg::CNT_W-1:0]       cap_lim;
    logic [lruc_pkg::CNT_W-1:0]       ec;
    logic                             any_hit;
    logic                             insert_go;
    logic                             find_go;
    logic [lruc_pkg::ITEM_BITS-1:0]   hit_item;
    logic [lruc_pkg::ITEM_BITS-1:0]   head_item;
    logic [lruc_pkg::STATUS_W-1:0]    status_val;

    logic [N-1:0]                     hit;
    logic [N-1:0]                     valid;
    logic [N-1:0]                     tail_hit;
    logic [lruc_pkg::KEY_BITS-1:0]    cell_key  [N];
    logic [lruc_pkg::ITEM_BITS-1:0]   cell_item [N];
    logic [lruc_pkg::ITEM_BITS-1:0]   item_acc  [N];
    lruc_pkg::cell_ctl_t              ctl       [N];

    assign req.ready = (state_reg == lruc_pkg::S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign upd       = (state_reg == lruc_pkg::S_UPDATE);

    // capacity zero acts as one, large values saturate
    assign cap_lim = (capacity_reg == '0) ? lruc_pkg::CNT_W'(1) :
                     (32'(capacity_reg) > N) ? lruc_pkg::CNT_W'(N) :
                     lruc_pkg::CNT_W'(capacity_reg);
    assign ec      = (count_reg >= cap_lim) ? (cap_lim - lruc_pkg::CNT_W'(1)) : count_reg;

    assign any_hit   = tail_hit[0];
    assign hit_item  = item_acc[N-1];
    assign insert_go = (op_reg == lruc_pkg::OP_INSERT) && !any_hit;
    assign find_go   = (op_reg == lruc_pkg::OP_FIND) && any_hit;
    assign head_item = (op_reg == lruc_pkg::OP_INSERT) ? item_reg : hit_item;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            // a find hit at slot p shifts slots 1..p
            if (i == N - 1)
            begin : g_last
                assign tail_hit[i] = hit[i];
            end
            else
            begin : g_mid
                assign tail_hit[i] = hit[i] | tail_hit[i+1];
            end

            if (i == 0)
            begin : g_first
                assign item_acc[i] = hit[i] ? cell_item[i] : '0;
            end
            else
            begin : g_rest
                assign item_acc[i] = (hit[i] ? cell_item[i] : '0) | item_acc[i-1];
            end

            always_comb
            begin
                ctl[i].cmp       = accept;
                ctl[i].upd       = upd;
                ctl[i].load      = (i == 0) && (insert_go || find_go);
                ctl[i].shift     = (i != 0) &&
                                   ((insert_go && (lruc_pkg::CNT_W'(i) <= ec)) ||
                                    (find_go && tail_hit[i]));
                ctl[i].valid_nxt = insert_go ? (lruc_pkg::CNT_W'(i) <= ec) : valid[i];
            end

            lruc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[i]),
                .probe_key (req.key),
                .prev_key  ((i == 0) ? key_reg   : cell_key[(i == 0) ? 0 : i-1]),
                .prev_item ((i == 0) ? head_item : cell_item[(i == 0) ? 0 : i-1]),
                .head_key  (key_reg),
                .head_item (head_item),
                .key       (cell_key[i]),
                .item      (cell_item[i]),
                .valid     (valid[i]),
                .hit       (hit[i])
            );
        end
    endgenerate

    always_comb
    begin
        case ({op_reg, any_hit})
            {lruc_pkg::OP_INSERT, 1'b0}: status_val = lruc_pkg::ST_INSERTED;
            {lruc_pkg::OP_INSERT, 1'b1}: status_val = lruc_pkg::ST_DUPLICATE;
            {lruc_pkg::OP_FIND, 1'b1}:   status_val = lruc_pkg::ST_FOUND;
            default:                     status_val = lruc_pkg::ST_MISS;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            lruc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = lruc_pkg::S_UPDATE;
                end
            end
            lruc_pkg::S_UPDATE:
            begin
                state_next     = lruc_pkg::S_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = lruc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lruc_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            capacity_reg  <= lruc_pkg::CAP_RESET;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (upd && insert_go)
            begin
                count_reg <= ec + lruc_pkg::CNT_W'(1);
            end
        end
    end

    // request and response payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.opcode;
            key_reg  <= req.key;
            item_reg <= req.item;
        end
        if (upd)
        begin
            status_reg <= status_val;
            found_reg  <= find_go ? hit_item : '0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.found_item = found_reg;

endmodule

/* test/tb_lru_key_value_cache_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// Drives insert and find requests into the lru key/value cache and checks
// each response against an in-bench recency-ordered cache model. Runs
// directed fill, eviction and duplicate cases, then random phases under
// several capacity settings with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 9;
    localparam int POOL_SIZE   = 24;

    typedef struct packed
    {
        lruc_pkg::opcode_t              op;
        logic [lruc_pkg::KEY_BITS-1:0]  key;
        logic [lruc_pkg::ITEM_BITS-1:0] item;
    } request_t;

    typedef struct packed
    {
        lruc_pkg::status_t              status;
        logic [lruc_pkg::ITEM_BITS-1:0] found_item;
    } lookup_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [lruc_pkg::CAP_W-1:0] cfg_wdata;

    lruc_req_if req_ch ();
    lruc_rsp_if rsp_ch ();

    lru_key_value_cache_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // cache model, slot 0 most recent
    logic [lruc_pkg::KEY_BITS-1:0]  model_keys  [lruc_pkg::MAX_ENTRIES];
    logic [lruc_pkg::ITEM_BITS-1:0] model_items [lruc_pkg::MAX_ENTRIES];
    int                             model_count;
    logic [lruc_pkg::CAP_W-1:0]     model_capacity;

    request_t       pending_requests   [$];
    lookup_result_t expected_responses [$];
    logic [lruc_pkg::KEY_BITS-1:0] key_pool [POOL_SIZE];
    int  phase_caps [NUM_PHASES] = '{3, 1, 0, 31, 16, 2, 20, 7, 16};
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  no_gaps = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic lookup_result_t lru_predict(request_t rq);
        lookup_result_t                 res;
        int                             pos;
        int                             lim;
        logic [lruc_pkg::KEY_BITS-1:0]  hit_key;
        logic [lruc_pkg::ITEM_BITS-1:0] hit_item;
        pos = -1;
        for (int i = 0; i < model_count; i++)
        begin
            if (pos < 0 && model_keys[i] == rq.key)
                pos = i;
        end
        res.found_item = '0;
        if (rq.op == lruc_pkg::OP_INSERT)
        begin
            if (pos >= 0)
                res.status = lruc_pkg::ST_DUPLICATE;
            else
            begin
                lim = (model_capacity == 0) ? 1 :
                      (model_capacity > lruc_pkg::MAX_ENTRIES) ?
                      lruc_pkg::MAX_ENTRIES : int'(model_capacity);
                // a lowered capacity drops least recent entries here
                if (model_count >= lim)
                    model_count = lim - 1;
                for (int i = model_count; i > 0; i--)
                begin
                    model_keys[i]  = model_keys[i-1];
                    model_items[i] = model_items[i-1];
                end
                model_keys[0]  = rq.key;
                model_items[0] = rq.item;
                model_count++;
                res.status = lruc_pkg::ST_INSERTED;
            end
        end
        else if (pos >= 0)
        begin
            hit_key  = model_keys[pos];
            hit_item = model_items[pos];
            for (int i = pos; i > 0; i--)
            begin
                model_keys[i]  = model_keys[i-1];
                model_items[i] = model_items[i-1];
            end
            model_keys[0]  = hit_key;
            model_items[0] = hit_item;
            res.status     = lruc_pkg::ST_FOUND;
            res.found_item = hit_item;
        end
        else
            res.status = lruc_pkg::ST_MISS;
        return res;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        lookup_result_t prediction;
        if (!rst_n)
        begin
            req_ch.valid  <= 1'b0;
            req_ch.opcode <= 1'b0;
            req_ch.key    <= '0;
            req_ch.item   <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                prediction = lru_predict(pending_requests[0]);
                expected_responses.push_back(prediction);
                void'(pending_requests.pop_front());
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 21))
                begin
                    req_ch.valid  <= 1'b1;
                    req_ch.opcode <= pending_requests[0].op;
                    req_ch.key    <= pending_requests[0].key;
                    req_ch.item   <= pending_requests[0].item;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        lookup_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response transaction: status %0d found_item %h",
                                 rsp_ch.status, rsp_ch.found_item);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.found_item !== want.found_item)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("response mismatch: expected %0d/%h, got %0d/%h",
                                     want.status, want.found_item,
                                     rsp_ch.status, rsp_ch.found_item);
                    end
                end
            end
            rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 21);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lru_key_value_cache_unit verification failed");
            $finish;
        end
    end

    task automatic queue_request(lruc_pkg::opcode_t op,
                                 logic [lruc_pkg::KEY_BITS-1:0] key,
                                 logic [lruc_pkg::ITEM_BITS-1:0] item);
        request_t rq;
        rq.op   = op;
        rq.key  = key;
        rq.item = item;
        pending_requests.push_back(rq);
    endtask

    task automatic queue_random_request(int span);
        request_t rq;
        int       roll;
        rq.op = lruc_pkg::opcode_t'($urandom_range(0, 1));
        // mostly pool keys so finds hit and inserts collide
        rq.key = ($urandom_range(0, 9) == 0) ? lruc_pkg::KEY_BITS'($urandom) :
                 key_pool[$urandom_range(0, span - 1)];
        roll = $urandom_range(0, 9);
        rq.item = (roll == 0) ? '0 : (roll == 1) ? '1 : lruc_pkg::ITEM_BITS'($urandom);
        pending_requests.push_back(rq);
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || expected_responses.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(logic [lruc_pkg::CAP_W-1:0] value);
        cfg_we         <= 1'b1;
        cfg_wdata      <= value;
        model_capacity  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int eff;
        int span;
        int count;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = 1'b0;
        req_ch.key    = '0;
        req_ch.item   = '0;
        rsp_ch.ready  = 1'b0;
        model_count    = 0;
        model_capacity = lruc_pkg::CAP_RESET;
        for (int i = 0; i < lruc_pkg::MAX_ENTRIES; i++)
        begin
            model_keys[i]  = '0;
            model_items[i] = '0;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = lruc_pkg::KEY_BITS'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty miss, zero item hit, duplicate, fill past capacity
        @(negedge clk);
        queue_request(lruc_pkg::OP_FIND,   32'h1234_5678, 32'h0);
        queue_request(lruc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        queue_request(lruc_pkg::OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(lruc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(lruc_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0005);
        queue_request(lruc_pkg::OP_FIND,   32'hFFFF_FFFF, 32'h0);
        for (int i = 1; i <= 15; i++)
            queue_request(lruc_pkg::OP_INSERT, lruc_pkg::KEY_BITS'(i),
                          lruc_pkg::ITEM_BITS'(i) * 32'h0101_0101);
        // key zero is least recent and gone after the last fill
        queue_request(lruc_pkg::OP_FIND,   32'h0000_0000, 32'h0);
        queue_request(lruc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_request(lruc_pkg::OP_FIND,   32'h0000_0001, 32'h0);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(lruc_pkg::CAP_W'(phase_caps[p]));
            eff  = (phase_caps[p] == 0) ? 1 :
                   (phase_caps[p] > lruc_pkg::MAX_ENTRIES) ?
                   lruc_pkg::MAX_ENTRIES : phase_caps[p];
            span = (eff + 6 > POOL_SIZE) ? POOL_SIZE : eff + 6;
            no_gaps = (p == 4);
            count   = no_gaps ? 90 : 45;
            @(negedge clk);
            for (int n = 0; n < count; n++)
                queue_random_request(span);
            wait_idle();
        end
        no_gaps = 1'b0;
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && expected_responses.size() == 0)
            $display("lru_key_value_cache_unit verification clean");
        else
            $display("lru_key_value_cache_unit verification failed");
        $finish;
    end

endmodule
